// File: hw/rtl/nsst_pkg.sv
package nsst_pkg;

    // store geometry
    localparam int MAX_STEPS = 64;
    localparam int ADDR_W    = $clog2(MAX_STEPS);
    localparam int LEN_W     = $clog2(MAX_STEPS + 1);
    localparam int NOTE_W    = 7;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_STEPS);

    // request codes
    localparam logic [2:0] REQ_SET    = 3'd0;
    localparam logic [2:0] REQ_LOAD   = 3'd1;
    localparam logic [2:0] REQ_GET    = 3'd2;
    localparam logic [2:0] REQ_SETLEN = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;
    localparam logic [2:0] REQ_XPOSE  = 3'd5;

    // configuration register indexes
    localparam logic CFG_LOW  = 1'b0;
    localparam logic CFG_HIGH = 1'b1;

    // limit reset values
    localparam logic [NOTE_W-1:0] LOW_RESET  = 7'd36;
    localparam logic [NOTE_W-1:0] HIGH_RESET = 7'd96;

    // commands from controller to datapath
    typedef struct packed {
        logic take;      // latch request, do the work that needs no store walk
        logic rd_issue;  // read store at walk counter, advance counter
        logic apply;     // walk is the write-back pass
        logic calc;      // settle the limited shift
        logic out_load;  // load the result register
    } nsst_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic len_zero;    // active length is zero
        logic last_issue;  // walk counter is at the last active step
        logic any_note;    // scan found a nonzero note
    } nsst_stat_t;

endpackage

// File: hw/rtl/note_sequence_store_transpose.sv
// Step-sequencer note store with an active length and a transpose walk.
// Request channel: in_valid / in_stall with req_type, step_index, note_value,
// new_length and semitones; a request is taken when in_valid is high and
// in_stall is low. One request is worked on at a time.
// Result channel: out_valid / out_stall with note_out, length_out, status;
// exactly one result per request, in request order.
// Set, load, get, set length, clear and unknown codes go straight to the
// finish state. Transpose over active length L makes a scan pass and a
// write-back pass over the store, one entry per cycle through its single
// read and write port; the write-back pass is skipped when no note within
// the length is nonzero, and both passes when L is zero. A new request is
// taken in the cycle after a result is loaded.
// The result sits in an output register: a stalled result holds and the
// next request may still be taken; its result waits until the register frees.
// Limits are written through cfg_we / cfg_index / cfg_data (index 0 low
// limit, index 1 high limit); the user must write them only while the block
// is idle, as the block itself does not enforce it.
// Reset (rst_n low, asynchronous) empties the store at once through per-entry
// valid bits, sets length 0 and limits 36 and 96; no clearing pass is needed.
module note_sequence_store_transpose (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        req_type,
    input  logic [5:0]        step_index,
    input  logic [6:0]        note_value,
    input  logic [6:0]        new_length,
    input  logic signed [7:0] semitones,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [6:0]        note_out,
    output logic [6:0]        length_out,
    output logic              status
);

    nsst_pkg::nsst_cmd_t  cmd;
    nsst_pkg::nsst_stat_t stat;

    // sequencer
    nsst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // store, length, limits and result register
    nsst_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_type   (req_type),
        .step_index (step_index),
        .note_value (note_value),
        .new_length (new_length),
        .semitones  (semitones),
        .cmd        (cmd),
        .stat       (stat),
        .note_out   (note_out),
        .length_out (length_out),
        .status     (status)
    );

    // a taken request stalls the next one in the following cycle
    a_take_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken back to back");

    // reported length never exceeds the store
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> length_out <= 7'(nsst_pkg::MAX_STEPS))
        else $error("length beyond store");

    // a nonzero read note only comes with an applied request
    a_note_applied: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && note_out != 7'd0 |-> status == 1'b0)
        else $error("note returned on ignored request");

    // a new result appears only while the block is between requests
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result loaded while busy");

endmodule

// File: hw/rtl/nsst_dp.sv
module nsst_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [6:0]                  cfg_data,
    input  logic [2:0]                  req_type,
    input  logic [5:0]                  step_index,
    input  logic [6:0]                  note_value,
    input  logic [6:0]                  new_length,
    input  logic signed [7:0]           semitones,
    input  nsst_pkg::nsst_cmd_t         cmd,
    output nsst_pkg::nsst_stat_t        stat,
    output logic [6:0]                  note_out,
    output logic [6:0]                  length_out,
    output logic                        status
);

    // note store, cleared through per-entry valid bits
    logic [nsst_pkg::NOTE_W-1:0] note_mem [nsst_pkg::MAX_STEPS];
    logic [nsst_pkg::MAX_STEPS-1:0] vld_reg, vld_next;

    logic [nsst_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [nsst_pkg::NOTE_W-1:0] low_reg, high_reg;
    logic [nsst_pkg::LEN_W-1:0]  cnt_reg;

    // read side
    logic                        rd_en;
    logic [nsst_pkg::ADDR_W-1:0] rd_addr;
    logic [nsst_pkg::NOTE_W-1:0] rdata_reg;
    logic                        rd_vld_reg;
    logic                        rd_pend_reg;
    logic                        pend_apply_reg;
    logic [nsst_pkg::ADDR_W-1:0] rd_addr_reg;

    // write side
    logic                        wr_en;
    logic [nsst_pkg::ADDR_W-1:0] wr_addr;
    logic [nsst_pkg::NOTE_W-1:0] wr_data;

    // transpose working values
    logic [nsst_pkg::NOTE_W-1:0] lo_reg, hi_reg;
    logic                        any_reg;
    logic signed [7:0]           shift_in_reg;
    logic signed [8:0]           shift_reg, shift_next;

    // request bookkeeping and result register
    logic                        status_reg, status_next;
    logic                        is_get_reg;
    logic [6:0]                  note_out_reg;
    logic [6:0]                  length_out_reg;
    logic                        status_out_reg;

    logic [nsst_pkg::LEN_W-1:0]  step_ext, nl_ext;
    logic                        ok;
    logic [nsst_pkg::NOTE_W-1:0] n_cur, n_clamp;
    logic signed [9:0]           sum_s, low_s, high_s, lo_s, hi_s, sh_in_s;

    assign step_ext = nsst_pkg::LEN_W'(step_index);
    assign nl_ext   = nsst_pkg::LEN_W'(new_length);
    assign n_cur    = rd_vld_reg ? rdata_reg : '0;

    assign low_s   = $signed({3'b000, low_reg});
    assign high_s  = $signed({3'b000, high_reg});
    assign lo_s    = $signed({3'b000, lo_reg});
    assign hi_s    = $signed({3'b000, hi_reg});
    assign sh_in_s = {{2{shift_in_reg[7]}}, shift_in_reg};
    assign sum_s   = $signed({3'b000, n_cur}) + {shift_reg[8], shift_reg};

    // clamp a moved note into the limits; when limits cross, notes below low take low, all others take high
    always_comb
    begin
        if (sum_s < low_s)
            n_clamp = low_reg;
        else if (sum_s > high_s)
            n_clamp = high_reg;
        else
            n_clamp = sum_s[nsst_pkg::NOTE_W-1:0];
    end

    // request decode, store and length updates
    always_comb
    begin
        ok       = 1'b0;
        len_next = len_reg;
        vld_next = vld_reg;
        wr_en    = 1'b0;
        wr_addr  = nsst_pkg::ADDR_W'(step_index);
        wr_data  = note_value;
        rd_en    = cmd.rd_issue;
        rd_addr  = cnt_reg[nsst_pkg::ADDR_W-1:0];
        if (cmd.take)
        begin
            unique case (req_type)
                nsst_pkg::REQ_SET:
                begin
                    ok    = step_ext < nsst_pkg::MAX_LEN;
                    wr_en = ok;
                    if (ok && step_ext >= len_reg)
                        len_next = step_ext + nsst_pkg::LEN_W'(1);
                end
                nsst_pkg::REQ_LOAD:
                begin
                    ok = (nl_ext != '0) && (nl_ext <= nsst_pkg::MAX_LEN)
                         && (step_ext < nl_ext);
                    wr_en = ok;
                    if (ok && step_ext == nl_ext - nsst_pkg::LEN_W'(1))
                        len_next = nl_ext;
                end
                nsst_pkg::REQ_GET:
                begin
                    ok      = step_ext < len_reg;
                    rd_en   = 1'b1;
                    rd_addr = nsst_pkg::ADDR_W'(step_index);
                end
                nsst_pkg::REQ_SETLEN:
                begin
                    ok = nl_ext <= nsst_pkg::MAX_LEN;
                    if (ok)
                        len_next = nl_ext;
                end
                nsst_pkg::REQ_CLEAR:
                begin
                    ok       = 1'b1;
                    vld_next = '0;
                    len_next = '0;
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
        end
        else if (rd_pend_reg && pend_apply_reg && n_cur != '0)
        begin
            wr_en   = 1'b1;
            wr_addr = rd_addr_reg;
            wr_data = n_clamp;
        end
        if (wr_en)
            vld_next[wr_addr] = 1'b1;
    end

    // limited shift and request status
    always_comb
    begin
        shift_next = shift_reg;
        if (cmd.calc)
        begin
            if (!shift_in_reg[7] && shift_in_reg != '0 && hi_s + sh_in_s > high_s)
                shift_next = 9'(high_s - hi_s);
            else if (shift_in_reg[7] && lo_s + sh_in_s < low_s)
                shift_next = 9'(low_s - lo_s);
            else
                shift_next = {shift_in_reg[7], shift_in_reg};
        end
        status_next = status_reg;
        if (cmd.take)
            status_next = !ok;
        else if (cmd.calc)
            status_next = !any_reg;
    end

    // store memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            note_mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= note_mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            len_reg        <= '0;
            low_reg        <= nsst_pkg::LOW_RESET;
            high_reg       <= nsst_pkg::HIGH_RESET;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            rd_pend_reg    <= 1'b0;
            pend_apply_reg <= 1'b0;
            any_reg        <= 1'b0;
            status_reg     <= 1'b1;
            is_get_reg     <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            len_reg <= len_next;
            if (cfg_we && cfg_index == nsst_pkg::CFG_LOW)
                low_reg <= cfg_data;
            if (cfg_we && cfg_index == nsst_pkg::CFG_HIGH)
                high_reg <= cfg_data;
            if (cmd.take || cmd.calc)
                cnt_reg <= '0;
            else if (cmd.rd_issue)
                cnt_reg <= cnt_reg + nsst_pkg::LEN_W'(1);
            if (rd_en)
                rd_vld_reg <= vld_reg[rd_addr];
            rd_pend_reg    <= cmd.rd_issue;
            pend_apply_reg <= cmd.apply;
            if (cmd.take)
                any_reg <= 1'b0;
            else if (rd_pend_reg && !pend_apply_reg && n_cur != '0)
                any_reg <= 1'b1;
            status_reg <= status_next;
            if (cmd.take)
                is_get_reg <= (req_type == nsst_pkg::REQ_GET);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr;
        shift_reg   <= shift_next;
        if (cmd.take)
        begin
            shift_in_reg <= semitones;
            lo_reg       <= 7'd127;
            hi_reg       <= '0;
        end
        else if (rd_pend_reg && !pend_apply_reg && n_cur != '0)
        begin
            if (n_cur < lo_reg)
                lo_reg <= n_cur;
            if (n_cur > hi_reg)
                hi_reg <= n_cur;
        end
        if (cmd.out_load)
        begin
            note_out_reg   <= (is_get_reg && !status_reg) ? n_cur : '0;
            length_out_reg <= 7'(len_reg);
            status_out_reg <= status_reg;
        end
    end

    assign stat.len_zero   = (len_reg == '0);
    assign stat.last_issue = (cnt_reg == len_reg - nsst_pkg::LEN_W'(1));
    assign stat.any_note   = any_reg;

    assign note_out   = note_out_reg;
    assign length_out = length_out_reg;
    assign status     = status_out_reg;

endmodule

// File: hw/rtl/nsst_ctrl.sv
module nsst_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            req_type,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  nsst_pkg::nsst_stat_t  stat,
    output nsst_pkg::nsst_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SCAN      = 3'd1;
    localparam logic [2:0] ST_SCAN_END  = 3'd2;
    localparam logic [2:0] ST_CALC      = 3'd3;
    localparam logic [2:0] ST_APPLY     = 3'd4;
    localparam logic [2:0] ST_APPLY_END = 3'd5;
    localparam logic [2:0] ST_FINISH    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // sequencing of request work
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (req_type == nsst_pkg::REQ_XPOSE && !stat.len_zero)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_issue = 1'b1;
                if (stat.last_issue)
                    state_next = ST_SCAN_END;
            end
            ST_SCAN_END:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc = 1'b1;
                state_next = stat.any_note ? ST_APPLY : ST_FINISH;
            end
            ST_APPLY:
            begin
                cmd.rd_issue = 1'b1;
                cmd.apply    = 1'b1;
                if (stat.last_issue)
                    state_next = ST_APPLY_END;
            end
            ST_APPLY_END:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register occupancy
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: test/nsst_checker.sv
module nsst_checker
    import nsst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_data,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [2:0]        req_type,
    input  logic [5:0]        step_index,
    input  logic [6:0]        note_value,
    input  logic [6:0]        new_length,
    input  logic signed [7:0] semitones,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [6:0]        note_out,
    input  logic [6:0]        length_out,
    input  logic              status,
    output int                mismatches,
    output int                outstanding
);

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [6:0]        length;
        logic              status;
    } seq_result_t;

    // shadow copy of the sequence store and the limits
    logic [NOTE_W-1:0] seq_notes [MAX_STEPS];
    int                seq_length;
    int                lim_low;
    int                lim_high;

    seq_result_t awaited_results [$];
    seq_result_t head;

    task automatic flag_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    function automatic void wipe_sequence();
        for (int i = 0; i < MAX_STEPS; i++)
        begin
            seq_notes[i] = '0;
        end
        seq_length = 0;
    endfunction

    // limited shift over the nonzero notes, then clamp each moved note
    function automatic logic transpose_notes(input int shift);
        int   lo;
        int   hi;
        int   n;
        logic found;
        lo    = 127;
        hi    = 0;
        found = 1'b0;
        for (int i = 0; i < seq_length; i++)
        begin
            n = seq_notes[i];
            if (n > 0)
            begin
                found = 1'b1;
                if (n < lo) lo = n;
                if (n > hi) hi = n;
            end
        end
        if (!found)
            return 1'b0;
        if (shift > 0 && hi + shift > lim_high)
            shift = lim_high - hi;
        else if (shift < 0 && lo + shift < lim_low)
            shift = lim_low - lo;
        for (int i = 0; i < seq_length; i++)
        begin
            n = seq_notes[i];
            if (n > 0)
            begin
                n = n + shift;
                if (n < lim_low)
                    n = lim_low;
                else if (n > lim_high)
                    n = lim_high;
                seq_notes[i] = NOTE_W'(n);
            end
        end
        return 1'b1;
    endfunction

    // update the shadow store for one request and form its result
    function automatic seq_result_t apply_request(
        input logic [2:0]        kind,
        input logic [ADDR_W-1:0] step,
        input logic [NOTE_W-1:0] note,
        input logic [6:0]        len,
        input logic signed [7:0] semis
    );
        seq_result_t r;
        int          step_i;
        int          len_i;
        r      = '0;
        r.status = 1'b1;
        step_i = int'(step);
        len_i  = int'(len);
        case (kind)
            REQ_SET:
            begin
                seq_notes[step] = note;
                if (step_i >= seq_length)
                    seq_length = step_i + 1;
                r.status = 1'b0;
            end
            REQ_LOAD:
            begin
                if (len_i > 0 && len_i <= MAX_STEPS && step_i < len_i)
                begin
                    seq_notes[step] = note;
                    if (step_i == len_i - 1)
                        seq_length = len_i;
                    r.status = 1'b0;
                end
            end
            REQ_GET:
            begin
                if (step_i < seq_length)
                begin
                    r.note   = seq_notes[step];
                    r.status = 1'b0;
                end
            end
            REQ_SETLEN:
            begin
                if (len_i <= MAX_STEPS)
                begin
                    seq_length = len_i;
                    r.status   = 1'b0;
                end
            end
            REQ_CLEAR:
            begin
                wipe_sequence();
                r.status = 1'b0;
            end
            REQ_XPOSE:
            begin
                r.status = !transpose_notes(int'(semis));
            end
            default:
            begin
                r.status = 1'b1;
            end
        endcase
        r.length = 7'(seq_length);
        return r;
    endfunction

    // sample mid-cycle: what is seen here is taken at the next rising edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            wipe_sequence();
            lim_low  = int'(LOW_RESET);
            lim_high = int'(HIGH_RESET);
            awaited_results.delete();
        end
        else
        begin
            // result side
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    flag_mismatch($sformatf("result note %0d length %0d status %0d with none pending",
                                            note_out, length_out, status));
                end
                else
                begin
                    head = awaited_results.pop_front();
                    if (note_out !== head.note)
                        flag_mismatch($sformatf("note_out got %0d expected %0d",
                                                note_out, head.note));
                    if (length_out !== head.length)
                        flag_mismatch($sformatf("length_out got %0d expected %0d",
                                                length_out, head.length));
                    if (status !== head.status)
                        flag_mismatch($sformatf("status got %0d expected %0d",
                                                status, head.status));
                end
            end
            // request side
            if (in_valid && !in_stall)
            begin
                awaited_results.push_back(apply_request(req_type, step_index, note_value,
                                                        new_length, semitones));
            end
            // limit writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LOW:  lim_low  = int'(cfg_data);
                    CFG_HIGH: lim_high = int'(cfg_data);
                endcase
            end
        end
        outstanding = awaited_results.size();
    end

endmodule

// File: test/tb.sv
module tb;
    import nsst_pkg::*;

    localparam logic [2:0] REQ_SPARE_A  = 3'd6;
    localparam logic [2:0] REQ_SPARE_B  = 3'd7;
    localparam int         IDLE_PCT     = 37;
    localparam int         PHASE_ITEMS  = 330;
    localparam int         PHASES       = 5;
    localparam int         SETTLE_TICKS = 150;
    localparam int         LIMIT_TICKS  = 2_000_000;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_we      = 1'b0;
    logic              cfg_index   = CFG_LOW;
    logic [6:0]        cfg_data    = '0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic [2:0]        req_type    = REQ_GET;
    logic [5:0]        step_index  = '0;
    logic [6:0]        note_value  = '0;
    logic [6:0]        new_length  = '0;
    logic signed [7:0] semitones   = '0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic [6:0]        note_out;
    logic [6:0]        length_out;
    logic              status;

    int mismatches;
    int outstanding;
    int tick_count  = 0;
    int items_sent  = 0;
    bit calm        = 1'b0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    note_sequence_store_transpose i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .step_index (step_index),
        .note_value (note_value),
        .new_length (new_length),
        .semitones  (semitones),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .note_out   (note_out),
        .length_out (length_out),
        .status     (status)
    );

    nsst_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .step_index  (step_index),
        .note_value  (note_value),
        .new_length  (new_length),
        .semitones   (semitones),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .note_out    (note_out),
        .length_out  (length_out),
        .status      (status),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // result side back-pressure
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // run guard
    always @(posedge clk)
    begin
        tick_count <= tick_count + 1;
        if (tick_count >= LIMIT_TICKS)
        begin
            $display("** note_sequence_store_transpose: FAILED **");
            $finish;
        end
    end

    // one request: optional idle gap, then hold until taken
    task automatic send_request(
        input logic [2:0]        kind,
        input logic [5:0]        step,
        input logic [6:0]        note,
        input logic [6:0]        len,
        input logic signed [7:0] semis
    );
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        step_index <= step;
        note_value <= note;
        new_length <= len;
        semitones  <= semis;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    // stop sending and wait for every pending result
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_limits(input logic [6:0] low, input logic [6:0] high);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LOW;
        cfg_data  <= low;
        @(posedge clk);
        cfg_index <= CFG_HIGH;
        cfg_data  <= high;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [6:0] pick_note();
        if ($urandom_range(7) == 0)
            return 7'd0;
        return 7'($urandom_range(127, 1));
    endfunction

    function automatic logic [6:0] pick_length();
        if ($urandom_range(7) == 0)
            return 7'($urandom_range(127, 65));
        return 7'($urandom_range(64, 0));
    endfunction

    function automatic logic signed [7:0] pick_shift();
        logic signed [7:0] s;
        if ($urandom_range(3) == 0)
            s = 8'($urandom);
        else
            s = 8'($urandom_range(24)) - 8'sd12;
        return s;
    endfunction

    // well-formed bulk load: steps 0..n-1 in order, last one fixes the length
    task automatic load_burst();
        int n;
        n = ($urandom_range(9) == 0) ? MAX_STEPS : $urandom_range(16, 1);
        for (int s = 0; s < n; s++)
            send_request(REQ_LOAD, 6'(s), pick_note(), 7'(n), pick_shift());
    endtask

    task automatic send_random();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            load_burst();
        else if (pick < 25)
            send_request(REQ_SET, 6'($urandom), pick_note(), 7'($urandom), 8'($urandom));
        else if (pick < 37)
            send_request(REQ_LOAD, 6'($urandom), pick_note(),
                         ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(64)),
                         8'($urandom));
        else if (pick < 60)
            send_request(REQ_GET,
                         $urandom_range(1) ? 6'($urandom_range(15)) : 6'($urandom),
                         7'($urandom), 7'($urandom), 8'($urandom));
        else if (pick < 68)
            send_request(REQ_SETLEN, 6'($urandom), 7'($urandom), pick_length(), 8'($urandom));
        else if (pick < 71)
            send_request(REQ_CLEAR, 6'($urandom), 7'($urandom), 7'($urandom), 8'($urandom));
        else if (pick < 97)
            send_request(REQ_XPOSE, 6'($urandom), 7'($urandom), 7'($urandom), pick_shift());
        else
            send_request($urandom_range(1) ? REQ_SPARE_A : REQ_SPARE_B, 6'($urandom),
                         7'($urandom), 7'($urandom), 8'($urandom));
    endtask

    initial
    begin
        int goal;
        // reset
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners under the reset limits
        send_request(REQ_GET,    6'd0,  7'd0,   7'd0,   8'sd0);    // get on empty store
        send_request(REQ_XPOSE,  6'd0,  7'd0,   7'd0,   8'sd5);    // nothing to transpose
        send_request(REQ_SET,    6'd63, 7'd127, 7'd0,   8'sd0);    // top step grows length
        send_request(REQ_SET,    6'd5,  7'd1,   7'd0,   8'sd0);
        send_request(REQ_SET,    6'd0,  7'd0,   7'd0,   8'sd0);    // rest
        send_request(REQ_GET,    6'd63, 7'd0,   7'd0,   8'sd0);
        send_request(REQ_GET,    6'd5,  7'd0,   7'd0,   8'sd0);
        send_request(REQ_GET,    6'd10, 7'd0,   7'd0,   8'sd0);    // unwritten, inside length
        send_request(REQ_SETLEN, 6'd0,  7'd0,   7'd65,  8'sd0);    // too long
        send_request(REQ_SETLEN, 6'd0,  7'd0,   7'd127, 8'sd0);
        send_request(REQ_XPOSE,  6'd0,  7'd0,   7'd0,   8'sd127);  // shift turns negative
        send_request(REQ_XPOSE,  6'd0,  7'd0,   7'd0,   -8'sd128);
        send_request(REQ_XPOSE,  6'd0,  7'd0,   7'd0,   8'sd0);
        send_request(REQ_SETLEN, 6'd0,  7'd0,   7'd0,   8'sd0);
        send_request(REQ_GET,    6'd0,  7'd0,   7'd0,   8'sd0);    // beyond length
        send_request(REQ_XPOSE,  6'd0,  7'd0,   7'd0,   8'sd3);    // zero length
        send_request(REQ_LOAD,   6'd0,  7'd50,  7'd0,   8'sd0);    // zero count
        send_request(REQ_LOAD,   6'd0,  7'd50,  7'd65,  8'sd0);    // count too large
        send_request(REQ_LOAD,   6'd10, 7'd50,  7'd10,  8'sd0);    // step outside count
        send_request(REQ_LOAD,   6'd3,  7'd20,  7'd10,  8'sd0);    // inner step
        send_request(REQ_LOAD,   6'd9,  7'd100, 7'd10,  8'sd0);    // last step sets length
        send_request(REQ_XPOSE,  6'd0,  7'd0,   7'd0,   -8'sd20);
        send_request(REQ_SPARE_A, 6'd1, 7'd1,   7'd1,   8'sd1);
        send_request(REQ_SPARE_B, 6'd2, 7'd2,   7'd2,   8'sd2);
        send_request(REQ_CLEAR,  6'd0,  7'd0,   7'd0,   8'sd0);
        send_request(REQ_GET,    6'd3,  7'd0,   7'd0,   8'sd0);

        // random phases, each under its own limits
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain_results();
                case (phase)
                    1:       set_limits(7'd0, 7'd127);
                    2:       set_limits(7'd127, 7'd0);
                    3:       set_limits(7'd70, 7'd50);
                    default: set_limits(7'($urandom), 7'($urandom));
                endcase
            end
            // one whole phase without any idling
            calm = (phase == 1);
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
                send_random();
        end

        // wind down and give the verdict
        drain_results();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (mismatches == 0)
            $display("** note_sequence_store_transpose: PASSED **");
        else
            $display("** note_sequence_store_transpose: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/nsst_pkg.sv
hw/rtl/nsst_dp.sv
hw/rtl/nsst_ctrl.sv
hw/rtl/note_sequence_store_transpose.sv
test/nsst_checker.sv
test/tb.sv
